### hw/rtl/sdl_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and calibration tables for the sensor distance linearizer.
// Depends on nothing; imported by the controller, the datapath and the top level.
package sdl_pkg;

    localparam int TABLE_POINTS = 13;
    localparam int SENSOR_COUNT = 3;

    localparam int SEL_W = 2;
    localparam int X_W   = 12;                        // converter sample
    localparam int Y_W   = 6;                         // calibration distance, whole cm
    localparam int IDX_W = $clog2(TABLE_POINTS);
    localparam int D_W   = X_W;                       // segment width xr - xl
    localparam int P1_W  = Y_W + D_W;                 // yl * d, unsigned
    localparam int P2_W  = (Y_W + 1) + (X_W + 1);     // (yr - yl) * (x - xl), signed
    localparam int S_W   = P2_W + 1;                  // signed sum of both products
    localparam int FRAC_W = 8;
    localparam int NUM_W = S_W + FRAC_W;              // dividend magnitude, Q.8
    localparam int CNT_W = $clog2(NUM_W);
    localparam int OUT_W = 16;

    localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'(32767);
    localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(32768);

    typedef logic [X_W-1:0] t_x;
    typedef logic [Y_W-1:0] t_y;

    localparam t_y DIST_CM [TABLE_POINTS] = '{
        6'd30, 6'd26, 6'd23, 6'd20, 6'd17, 6'd15, 6'd13, 6'd10, 6'd8, 6'd6, 6'd5, 6'd4, 6'd2
    };

    localparam t_x SAMPLE_PTS [SENSOR_COUNT][TABLE_POINTS] = '{
        '{12'd22, 12'd23, 12'd40, 12'd150, 12'd305, 12'd420, 12'd505,
          12'd675, 12'd830, 12'd1080, 12'd1250, 12'd1500, 12'd2600},
        '{12'd26, 12'd37, 12'd50, 12'd70, 12'd145, 12'd270, 12'd420,
          12'd670, 12'd850, 12'd1120, 12'd1300, 12'd1600, 12'd2700},
        '{12'd23, 12'd24, 12'd25, 12'd75, 12'd250, 12'd360, 12'd475,
          12'd670, 12'd830, 12'd1070, 12'd1280, 12'd1500, 12'd2430}
    };

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic search_step;
        logic mul;
        logic sum;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
    } t_status;

endpackage

### hw/rtl/sdl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the linearizer: handshakes, search, multiply, divide, result load.
// Depends on sdl_pkg.
module sdl_ctrl
    import sdl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(NUM_W - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.search_done) begin
                    n_state = ST_MUL;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_ITER) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/sdl_dpath.sv
`timescale 1ns / 1ps
// Linearizer datapath: segment search, products, bit-serial divider, saturation.
// Depends on sdl_pkg; driven by sdl_ctrl commands.
module sdl_dpath
    import sdl_pkg::*;
(
    input  logic                    i_clk,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [SEL_W-1:0]        i_sensor_sel,
    input  logic [X_W-1:0]          i_adc_sample,
    output logic signed [OUT_W-1:0] o_distance_q8,
    output logic                    o_clipped
);

    logic [SEL_W-1:0]        r_sel;
    t_x                      r_x;
    logic [IDX_W-1:0]        r_lo, r_hi;
    logic [D_W-1:0]          r_d;
    logic [P1_W-1:0]         r_p1;
    logic signed [P2_W-1:0]  r_p2;
    logic                    r_neg;
    logic [NUM_W-1:0]        r_quo;
    logic [D_W-1:0]          r_rem;
    logic signed [OUT_W-1:0] r_dist;
    logic                    r_clip;

    logic [SEL_W-1:0]        w_sel;
    logic [IDX_W:0]          w_mid_sum;
    logic [IDX_W-1:0]        w_mid, w_lo_p1;
    t_x                      w_xl, w_xr;
    t_y                      w_yl, w_yr;
    logic signed [Y_W:0]     w_dy;
    logic signed [X_W:0]     w_dx;
    logic signed [S_W-1:0]   w_sum;
    logic [S_W-1:0]          w_mag;
    logic [D_W:0]            w_trial;
    logic                    w_fits;
    logic                    w_pos_ovf, w_neg_ovf;
    logic [OUT_W-1:0]        w_q16;

    // out-of-range sensor numbers use the last table
    assign w_sel = (i_sensor_sel >= SEL_W'(SENSOR_COUNT)) ? SEL_W'(SENSOR_COUNT - 1)
                                                          : i_sensor_sel;

    // upper midpoint keeps the search converging onto the last point <= sample
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
    assign w_mid     = w_mid_sum[IDX_W:1];
    assign o_status.search_done = (r_lo == r_hi);

    assign w_lo_p1 = r_lo + 1'b1;
    assign w_xl    = SAMPLE_PTS[r_sel][r_lo];
    assign w_xr    = SAMPLE_PTS[r_sel][w_lo_p1];
    assign w_yl    = DIST_CM[r_lo];
    assign w_yr    = DIST_CM[w_lo_p1];
    assign w_dy    = $signed({1'b0, w_yr}) - $signed({1'b0, w_yl});
    assign w_dx    = $signed({1'b0, r_x}) - $signed({1'b0, w_xl});

    assign w_sum = $signed({{(S_W - P1_W){1'b0}}, r_p1})
                 + $signed({{(S_W - P2_W){r_p2[P2_W-1]}}, r_p2});
    assign w_mag = w_sum[S_W-1] ? (~w_sum + 1'b1) : w_sum;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_d});

    assign w_pos_ovf = !r_neg && (r_quo > POS_LIMIT);
    assign w_neg_ovf =  r_neg && (r_quo > NEG_LIMIT);
    assign w_q16     = r_quo[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sel <= w_sel;
            r_x   <= i_adc_sample;
            r_lo  <= '0;
            r_hi  <= IDX_W'(TABLE_POINTS - 2);
        end
        if (i_cmd.search_step) begin
            if (SAMPLE_PTS[r_sel][w_mid] <= r_x) begin
                r_lo <= w_mid;
            end else begin
                r_hi <= w_mid - 1'b1;
            end
        end
        if (i_cmd.mul) begin
            r_d  <= w_xr - w_xl;
            r_p1 <= w_yl * (w_xr - w_xl);
            r_p2 <= w_dy * w_dx;
        end
        if (i_cmd.sum) begin
            r_neg <= w_sum[S_W-1];
            r_quo <= {w_mag, {FRAC_W{1'b0}}};
            r_rem <= '0;
        end
        // restoring divide of the magnitude; quotient bits shift in behind the dividend
        if (i_cmd.div_step) begin
            if (w_fits) begin
                r_rem <= D_W'(w_trial - {1'b0, r_d});
            end else begin
                r_rem <= w_trial[D_W-1:0];
            end
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
        if (i_cmd.load_out) begin
            if (w_pos_ovf) begin
                r_dist <= 16'sh7fff;
            end else if (w_neg_ovf) begin
                r_dist <= 16'sh8000;
            end else if (r_neg) begin
                r_dist <= $signed(~w_q16 + 1'b1);
            end else begin
                r_dist <= $signed(w_q16);
            end
            r_clip <= w_pos_ovf || w_neg_ovf;
        end
    end

    assign o_distance_q8 = r_dist;
    assign o_clipped     = r_clip;

endmodule

### hw/rtl/sensor_distance_linearizer.sv
`timescale 1ns / 1ps
// Top level of the sensor distance linearizer: controller plus datapath.
// Depends on sdl_pkg, sdl_ctrl and sdl_dpath.

// Converts a 12-bit proximity sensor sample into a distance in signed Q8.8
// centimetres by piecewise-linear interpolation over a fixed 13-point
// calibration table per sensor (0 right, 1 front, 2 left; higher numbers use
// the left table). Samples outside a table are extrapolated along its end
// segments; the result is truncated toward zero and saturated, with o_clipped
// flagging saturation. One word is worked on at a time: after acceptance come
// three or four binary search steps, one multiply, one add, and a bit-serial
// divider that dominates, and a new word is taken the cycle after the result
// is loaded. The result sits in an output register, so the block accepts the
// next word while the previous result still waits to be taken.
module sensor_distance_linearizer
    import sdl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SEL_W-1:0]        i_sensor_sel,
    input  logic [X_W-1:0]          i_adc_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_distance_q8,
    output logic                    o_clipped
);

    t_cmd    w_cmd;
    t_status w_status;

    sdl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sdl_dpath u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sensor_sel  (i_sensor_sel),
        .i_adc_sample  (i_adc_sample),
        .o_distance_q8 (o_distance_q8),
        .o_clipped     (o_clipped)
    );

endmodule
